// File: hw/rtl/io_register_bank_with_irq_defines.svh
// ----------------------------------------------------------------------------
// io register bank assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef IO_REGISTER_BANK_WITH_IRQ_DEFINES_SVH
`define IO_REGISTER_BANK_WITH_IRQ_DEFINES_SVH

`ifndef SYNTHESIS

// check a property on every edge outside of reset
`define IOIRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every edge, reset included
`define IOIRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IOIRQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define IOIRQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hw/rtl/ioirq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io register bank package
// request and response types, action codes and fixed register indexes
// ----------------------------------------------------------------------------
package ioirq_pkg;

	localparam int DATA_W    = 32;
	localparam int PC_W      = 12;
	localparam int ACT_W     = 2;
	// index width that covers the largest supported bank (32 registers)
	localparam int REG_IDX_W = 5;
	localparam int ADDR_W    = DATA_W + 1;

	// action codes
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RETI  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_IRQ   = 2'd3;

	// fixed register map
	localparam int REG_EN_BASE     = 0;
	localparam int REG_STAT_BASE   = 3;
	localparam int IRQ_PAIRS       = 3;
	localparam int REG_IRQ_HANDLER = 6;
	localparam int REG_IRQ_RETURN  = 7;
	localparam int REG_MONITOR_CMD = 22;

	// status codes
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_BAD_ADDR = 1'b1;

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic signed [DATA_W-1:0] base_value;
		logic signed [DATA_W-1:0] offset_value;
		logic signed [DATA_W-1:0] write_value;
		logic [PC_W-1:0]          current_pc;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic [PC_W-1:0]          next_pc;
		logic                     status;
		logic                     irq_taken;
	} result_t;

	// register bank update for one request
	typedef struct packed {
		logic                 wr_en;
		logic [REG_IDX_W-1:0] wr_idx;
		logic [DATA_W-1:0]    wr_data;
		logic                 irq_take;
		logic [PC_W-1:0]      irq_pc;
		logic [IRQ_PAIRS-1:0] irq_clr;
	} upd_t;

endpackage

// File: hw/rtl/ioirq_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io register bank stream interface
// valid/ready channel carrying one payload of type T
// ----------------------------------------------------------------------------
interface ioirq_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/ioirq_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io register bank storage
// flip-flop register file, one general write plus interrupt entry updates
// ----------------------------------------------------------------------------
module ioirq_regfile #(
	parameter int NUM_IO_REGS = 23
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            commit,
	input  ioirq_pkg::upd_t                                 upd,
	output logic [NUM_IO_REGS-1:0][ioirq_pkg::DATA_W-1:0]   regs
);

	localparam int IDX_W = $clog2(NUM_IO_REGS);

	logic [NUM_IO_REGS-1:0][ioirq_pkg::DATA_W-1:0] regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (commit) begin
			if (upd.wr_en) begin
				regs_q[upd.wr_idx[IDX_W-1:0]] <= upd.wr_data;
			end
			if (upd.irq_take) begin
				regs_q[ioirq_pkg::REG_IRQ_RETURN] <=
					{{(ioirq_pkg::DATA_W - ioirq_pkg::PC_W){1'b0}}, upd.irq_pc};
				for (int i = 0; i < ioirq_pkg::IRQ_PAIRS; i++) begin
					if (upd.irq_clr[i]) begin
						regs_q[ioirq_pkg::REG_STAT_BASE + i] <= '0;
					end
				end
			end
		end
	end

	assign regs = regs_q;

endmodule

// File: hw/rtl/ioirq_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io register bank execute logic
// address check, register read, interrupt decision and update request
// ----------------------------------------------------------------------------
module ioirq_exec #(
	parameter int NUM_IO_REGS = 23
) (
	input  ioirq_pkg::item_t                                item,
	input  logic [NUM_IO_REGS-1:0][ioirq_pkg::DATA_W-1:0]   regs,
	output ioirq_pkg::result_t                              res,
	output ioirq_pkg::upd_t                                 upd
);

	localparam int IDX_W = $clog2(NUM_IO_REGS);

	logic [ioirq_pkg::ADDR_W-1:0]    addr;
	logic                            addr_ok;
	logic [ioirq_pkg::REG_IDX_W-1:0] idx;
	logic [ioirq_pkg::IRQ_PAIRS-1:0] fired;
	logic                            irq_go;
	logic [ioirq_pkg::PC_W-1:0]      pc_inc;

	// exact 33-bit sum, negative or too large is out of range
	assign addr    = {item.base_value[ioirq_pkg::DATA_W-1], item.base_value}
	               + {item.offset_value[ioirq_pkg::DATA_W-1], item.offset_value};
	assign addr_ok = !addr[ioirq_pkg::ADDR_W-1]
	               && (addr < ioirq_pkg::ADDR_W'(NUM_IO_REGS));
	assign idx     = addr[ioirq_pkg::REG_IDX_W-1:0];
	assign pc_inc  = item.current_pc + ioirq_pkg::PC_W'(1);

	always_comb begin
		for (int i = 0; i < ioirq_pkg::IRQ_PAIRS; i++) begin
			fired[i] = |(regs[ioirq_pkg::REG_EN_BASE + i] & regs[ioirq_pkg::REG_STAT_BASE + i]);
		end
	end

	// pc is compared zero-extended against the full handler word
	assign irq_go = (|fired) && ({{(ioirq_pkg::DATA_W - ioirq_pkg::PC_W){1'b0}},
	                item.current_pc} != regs[ioirq_pkg::REG_IRQ_HANDLER]);

	always_comb begin
		res.read_data = '0;
		res.next_pc   = item.current_pc;
		res.status    = ioirq_pkg::STATUS_OK;
		res.irq_taken = 1'b0;
		upd.wr_en     = 1'b0;
		upd.wr_idx    = idx;
		upd.wr_data   = item.write_value;
		upd.irq_take  = 1'b0;
		upd.irq_pc    = item.current_pc;
		upd.irq_clr   = fired;
		if (item.action == ioirq_pkg::ACT_IRQ) begin
			if (irq_go) begin
				res.next_pc   = regs[ioirq_pkg::REG_IRQ_HANDLER][ioirq_pkg::PC_W-1:0];
				res.irq_taken = 1'b1;
				upd.irq_take  = 1'b1;
			end
		end else if (!addr_ok) begin
			res.status = ioirq_pkg::STATUS_BAD_ADDR;
		end else begin
			case (item.action)
				ioirq_pkg::ACT_READ: begin
					res.read_data = regs[idx[IDX_W-1:0]];
					res.next_pc   = pc_inc;
					// monitor command register clears once read
					if (idx == ioirq_pkg::REG_IDX_W'(ioirq_pkg::REG_MONITOR_CMD)) begin
						upd.wr_en   = 1'b1;
						upd.wr_data = '0;
					end
				end
				ioirq_pkg::ACT_WRITE: begin
					res.next_pc = pc_inc;
					upd.wr_en   = 1'b1;
				end
				ioirq_pkg::ACT_RETI: begin
					res.next_pc = regs[ioirq_pkg::REG_IRQ_RETURN][ioirq_pkg::PC_W-1:0];
				end
				default: begin
					res.next_pc = item.current_pc;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/io_register_bank_with_irq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io register bank with interrupt entry
// i/o register file serving read, write, return from interrupt and irq check
// ----------------------------------------------------------------------------
// usage
//   item   : request channel (valid/ready), one action per request with the
//            two address operands, write data and the current pc
//   result : response channel (valid/ready), read data, next pc, status and
//            the interrupt taken flag, exactly one response per request
// request path
//   a request accepted into the input register has its response loaded into
//   the output register when it advances; it is visible to the receiver from
//   then on
// throughput
//   one request per cycle while not stalled; the execute step between the
//   input and output registers is a 33-bit address add/compare and a register
//   mux against the flip-flop bank, and the bank is updated in that same cycle
// reset
//   arst_n clears every i/o register to zero and empties both stages
// stall
//   while the receiver holds ready low the response stays in the output
//   register; one more request may wait in the input register, after which
//   item.ready drops until the response is taken
// ----------------------------------------------------------------------------
`include "io_register_bank_with_irq_defines.svh"

module io_register_bank_with_irq #(
	parameter int NUM_IO_REGS = 23
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ioirq_stream_if.sink          item,
	ioirq_stream_if.source        result
);

	// input stage
	logic               valid_s1;
	ioirq_pkg::item_t   item_s1;

	// output stage
	logic               out_valid_q;
	ioirq_pkg::result_t result_q;

	// execute step
	ioirq_pkg::result_t res_d;
	ioirq_pkg::upd_t    upd_d;
	logic [NUM_IO_REGS-1:0][ioirq_pkg::DATA_W-1:0] regs;

	// request in the input stage moves on when the output register is free
	// or being emptied this cycle
	logic advance;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// payload needs no reset, loaded on every accepted request
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	// register bank, committed in the cycle the response is produced so the
	// next request already sees the new contents
	ioirq_regfile #(
		.NUM_IO_REGS(NUM_IO_REGS)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.upd    (upd_d),
		.regs   (regs)
	);

	ioirq_exec #(
		.NUM_IO_REGS(NUM_IO_REGS)
	) u_exec (
		.item (item_s1),
		.regs (regs),
		.res  (res_d),
		.upd  (upd_d)
	);

	// output register: fill on advance, drain on handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = result_q;

	// an interrupt entry never reports a bad address
	`IOIRQ_ASSERT(a_irq_status_ok, clk, arst_n, out_valid_q |-> !(result_q.irq_taken && result_q.status), "irq taken with bad address status")

	// a waiting request moves into a free output register on the next edge
	`IOIRQ_ASSERT(a_stage_moves, clk, arst_n, (valid_s1 && !out_valid_q) |=> out_valid_q, "request stuck in input stage")

	// both stages full and receiver stalled: no new request is taken
	`IOIRQ_ASSERT(a_backpressure, clk, arst_n, (valid_s1 && out_valid_q && !result.ready) |-> !item.ready, "request accepted into full pipeline")

	// bad address leaves the pc where it was
	`IOIRQ_ASSERT(a_bad_addr_pc, clk, arst_n, (advance && res_d.status) |=> (result_q.next_pc == $past(item_s1.current_pc)), "pc moved on bad address")

endmodule
